// ===== rtl/i2cejs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cejs_pkg
// Shared types and constants of the i2c eeprom job sequencer.
// ----------------------------------------------------------------------------
package i2cejs_pkg;

    localparam int BUFFER_DEPTH = 8;
    localparam int BUF_IDX_W    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAIT_TICKS = 1'd1;

    localparam logic [6:0]  DEVICE_ADDRESS_RST   = 7'd80;
    localparam logic [14:0] WRITE_WAIT_TICKS_RST = 15'd5;

    typedef enum logic [2:0] {
        OP_STEP        = 3'd0,
        OP_LOAD        = 3'd1,
        OP_START_WRITE = 3'd2,
        OP_START_READ  = 3'd3,
        OP_QUERY       = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        BOP_START = 3'd0,
        BOP_WRITE = 3'd1,
        BOP_ACK   = 3'd2,
        BOP_READ  = 3'd3,
        BOP_NACK  = 3'd4,
        BOP_STOP  = 3'd5
    } t_bus_op;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START_REQ   = 5'd1,
        PH_START_WAIT  = 5'd2,
        PH_DEVW_REQ    = 5'd3,
        PH_DEVW_WAIT   = 5'd4,
        PH_ACK_REQ     = 5'd5,
        PH_ACK_WAIT    = 5'd6,
        PH_ADDR_REQ    = 5'd7,
        PH_ADDR_WAIT   = 5'd8,
        PH_DATA_REQ    = 5'd9,
        PH_DATA_WAIT   = 5'd10,
        PH_RSTART_REQ  = 5'd11,
        PH_RSTART_WAIT = 5'd12,
        PH_DEVR_REQ    = 5'd13,
        PH_DEVR_WAIT   = 5'd14,
        PH_READ_REQ    = 5'd15,
        PH_READ_WAIT   = 5'd16,
        PH_STOP_REQ    = 5'd17,
        PH_STOP_WAIT   = 5'd18,
        PH_WRITE_WAIT  = 5'd19,
        PH_DONE        = 5'd20,
        PH_NACK_REQ    = 5'd21,
        PH_NACK_WAIT   = 5'd22
    } t_phase;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       job_done;
        logic       busy_res;
        logic [7:0] bus_byte;
        logic [2:0] bus_op;
        logic       bus_req_valid;
        logic       accepted;
    } t_result;

endpackage

// ===== rtl/i2c_eeprom_job_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_job_sequencer_top
// Turns eeprom page write and read jobs into a series of i2c primitives.
// ----------------------------------------------------------------------------
// One item is taken in every cycle while the result register can advance, and
// each item gives one result, passing through the input register and then the
// result register. The phase transition logic decides a single step from the
// registered phase and the handshake bits of the item. The eight-byte buffer
// is held in flip-flops and cleared at reset at once, so there is no clearing
// pass. Configuration is written through a plain write port; the user must
// write it only while the block is idle, as the block does not enforce this.
module i2c_eeprom_job_sequencer_top
    import i2cejs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tick_now[15:0], bus_ready[16], bus_done[17], bus_read_byte[25:18],
    // mem_address[33:26], byte_count[38:34], slot[42:39], load_byte[50:43]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[2:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted[0], bus_req_valid[1], bus_op[4:2], bus_byte[12:5],
    // busy_res[13], job_done[14], query_byte[22:15]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // configuration
    logic [6:0]  r_dev_addr;
    logic [14:0] r_wait_ticks;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [15:0] r_in_tick;
    logic        r_in_ready;
    logic        r_in_done;
    logic [7:0]  r_in_rd;
    logic [7:0]  r_in_addr;
    logic [4:0]  r_in_count;
    logic [3:0]  r_in_slot;
    logic [7:0]  r_in_ld;

    // job state
    t_phase      r_phase, n_phase;
    t_phase      r_ret_phase, n_ret_phase;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_base, n_base;
    logic [4:0]  r_len, n_len;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_wake, n_wake;
    logic [7:0]  r_store [BUFFER_DEPTH];

    // result register
    logic        r_out_valid;
    t_result     r_out;

    logic        w_adv;
    logic        w_fire;
    logic        w_step;
    logic        w_issue_ok;
    logic        w_busy;
    logic        w_start_ok;
    logic        w_load_ok;
    logic [4:0]  w_rd_pos;
    logic [7:0]  w_rd_byte;
    logic        w_wr_en;
    logic [4:0]  w_wr_pos;
    logic [7:0]  w_wr_byte;
    logic [15:0] w_diff;
    logic        w_req_valid;
    t_bus_op     w_bus_op;
    logic [7:0]  w_bus_byte;
    logic        w_accepted;
    t_result     w_res;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_step     = (r_in_op == OP_STEP);
    assign w_issue_ok = w_step && r_in_ready;
    assign w_busy     = (r_phase != PH_IDLE) && (r_phase != PH_DONE);
    assign w_start_ok = !w_busy && (r_in_count != 5'd0)
                        && (r_in_count <= 5'(BUFFER_DEPTH));
    assign w_load_ok  = !w_busy && ({1'b0, r_in_slot} < 5'(BUFFER_DEPTH));

    // one read port: the query slot or the current byte position
    assign w_rd_pos  = (r_in_op == OP_QUERY) ? {1'b0, r_in_slot} : r_pos;
    assign w_rd_byte = (w_rd_pos < 5'(BUFFER_DEPTH)) ? r_store[w_rd_pos[BUF_IDX_W-1:0]]
                                                      : 8'd0;

    assign w_diff = r_in_tick - r_wake;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_ret_phase = r_ret_phase;
        n_kind      = r_kind;
        n_base      = r_base;
        n_len       = r_len;
        n_pos       = r_pos;
        n_wake      = r_wake;
        w_accepted  = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_pos    = {1'b0, r_in_slot};
        w_wr_byte   = r_in_ld;
        unique case (r_in_op) inside
            OP_STEP: begin
                unique case (r_phase)
                    PH_START_REQ:   if (w_issue_ok) n_phase = PH_START_WAIT;
                    PH_START_WAIT:  if (r_in_done) n_phase = PH_DEVW_REQ;
                    PH_DEVW_REQ:    if (w_issue_ok) n_phase = PH_DEVW_WAIT;
                    PH_DEVW_WAIT: begin
                        if (r_in_done) begin
                            n_ret_phase = PH_ADDR_REQ;
                            n_phase     = PH_ACK_REQ;
                        end
                    end
                    PH_ACK_REQ:     if (w_issue_ok) n_phase = PH_ACK_WAIT;
                    PH_ACK_WAIT:    if (r_in_done) n_phase = r_ret_phase;
                    PH_ADDR_REQ:    if (w_issue_ok) n_phase = PH_ADDR_WAIT;
                    PH_ADDR_WAIT: begin
                        if (r_in_done) begin
                            n_ret_phase = (r_kind == KIND_WRITE) ? PH_DATA_REQ : PH_RSTART_REQ;
                            n_phase     = PH_ACK_REQ;
                        end
                    end
                    PH_DATA_REQ:    if (w_issue_ok) n_phase = PH_DATA_WAIT;
                    PH_DATA_WAIT: begin
                        if (r_in_done) begin
                            n_pos       = r_pos + 5'd1;
                            n_ret_phase = (n_pos >= r_len) ? PH_STOP_REQ : PH_DATA_REQ;
                            n_phase     = PH_ACK_REQ;
                        end
                    end
                    PH_RSTART_REQ:  if (w_issue_ok) n_phase = PH_RSTART_WAIT;
                    PH_RSTART_WAIT: if (r_in_done) n_phase = PH_DEVR_REQ;
                    PH_DEVR_REQ:    if (w_issue_ok) n_phase = PH_DEVR_WAIT;
                    PH_DEVR_WAIT: begin
                        if (r_in_done) begin
                            n_ret_phase = PH_READ_REQ;
                            n_phase     = PH_ACK_REQ;
                        end
                    end
                    PH_READ_REQ:    if (w_issue_ok) n_phase = PH_READ_WAIT;
                    PH_READ_WAIT: begin
                        if (r_in_done) begin
                            // a byte for a position beyond the buffer is dropped
                            w_wr_en   = (r_pos < 5'(BUFFER_DEPTH));
                            w_wr_pos  = r_pos;
                            w_wr_byte = r_in_rd;
                            n_pos     = r_pos + 5'd1;
                            n_phase   = PH_NACK_REQ;
                        end
                    end
                    PH_NACK_REQ:    if (w_issue_ok) n_phase = PH_NACK_WAIT;
                    PH_NACK_WAIT:   if (r_in_done) n_phase = PH_STOP_REQ;
                    PH_STOP_REQ:    if (w_issue_ok) n_phase = PH_STOP_WAIT;
                    PH_STOP_WAIT: begin
                        if (r_in_done) begin
                            if (r_kind == KIND_WRITE) begin
                                n_wake  = r_in_tick + {1'b0, r_wait_ticks};
                                n_phase = PH_WRITE_WAIT;
                            end else if (r_pos < r_len) begin
                                n_phase = PH_START_REQ;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    // wrap-safe: reached once the tick is at or past the wake point
                    PH_WRITE_WAIT:  if (!w_diff[15]) n_phase = PH_DONE;
                    default: ;
                endcase
            end
            OP_LOAD: begin
                if (w_load_ok) begin
                    w_wr_en    = 1'b1;
                    w_accepted = 1'b1;
                end
            end
            OP_START_WRITE, OP_START_READ: begin
                if (w_start_ok) begin
                    n_base     = r_in_addr;
                    n_len      = r_in_count;
                    n_pos      = 5'd0;
                    n_kind     = (r_in_op == OP_START_WRITE) ? KIND_WRITE : KIND_READ;
                    n_phase    = PH_START_REQ;
                    w_accepted = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // primitive issued on this step
    always_comb begin
        w_req_valid = 1'b0;
        w_bus_op    = BOP_START;
        w_bus_byte  = 8'd0;
        if (w_issue_ok) begin
            unique case (r_phase) inside
                PH_START_REQ, PH_RSTART_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_START;
                end
                PH_DEVW_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_WRITE;
                    w_bus_byte  = {r_dev_addr, 1'b0};
                end
                PH_DEVR_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_WRITE;
                    w_bus_byte  = {r_dev_addr, 1'b1};
                end
                PH_ADDR_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_WRITE;
                    w_bus_byte  = r_base + {3'd0, r_pos};
                end
                PH_DATA_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_WRITE;
                    w_bus_byte  = w_rd_byte;
                end
                PH_ACK_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_ACK;
                end
                PH_READ_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_READ;
                end
                PH_NACK_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_NACK;
                end
                PH_STOP_REQ: begin
                    w_req_valid = 1'b1;
                    w_bus_op    = BOP_STOP;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_res.accepted      = w_accepted;
        w_res.bus_req_valid = w_req_valid;
        w_res.bus_op        = w_bus_op;
        w_res.bus_byte      = w_bus_byte;
        w_res.busy_res      = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        w_res.job_done      = (n_phase == PH_DONE);
        w_res.query_byte    = (r_in_op == OP_QUERY) ? w_rd_byte : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= DEVICE_ADDRESS_RST;
            r_wait_ticks <= WRITE_WAIT_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS:   r_dev_addr   <= i_cfg_data[6:0];
                CFG_WRITE_WAIT_TICKS: r_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_tick  <= s_axis_tdata[15:0];
            r_in_ready <= s_axis_tdata[16];
            r_in_done  <= s_axis_tdata[17];
            r_in_rd    <= s_axis_tdata[25:18];
            r_in_addr  <= s_axis_tdata[33:26];
            r_in_count <= s_axis_tdata[38:34];
            r_in_slot  <= s_axis_tdata[42:39];
            r_in_ld    <= s_axis_tdata[50:43];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ret_phase <= PH_IDLE;
            r_kind      <= KIND_NONE;
            r_base      <= 8'd0;
            r_len       <= 5'd0;
            r_pos       <= 5'd0;
            r_wake      <= 16'd0;
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (w_fire) begin
            r_phase     <= n_phase;
            r_ret_phase <= n_ret_phase;
            r_kind      <= n_kind;
            r_base      <= n_base;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_wake      <= n_wake;
            if (w_wr_en) begin
                r_store[w_wr_pos[BUF_IDX_W-1:0]] <= w_wr_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // an issued primitive always leaves the job in progress
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.bus_req_valid || r_out.busy_res))
        else $error("primitive issued without a job in progress");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.job_done && r_out.busy_res))
        else $error("job reported done and busy together");

    // the phase only moves when an item passes into the result register
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_phase))
        else $error("phase changed without a transfer");

    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (r_pos <= r_len))
        else $error("byte position beyond job length");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.accepted |-> !r_out.bus_req_valid)
        else $error("request taken and primitive issued by one transfer");

endmodule
